/* sv/fwms_pkg.sv */
package fwms_pkg;

	localparam int TEXT_LEN = 64;
	localparam int ADDR_W   = $clog2(TEXT_LEN);
	localparam int CNT_W    = $clog2(TEXT_LEN + 1);
	localparam int ROW_W    = 17;
	localparam int SUM_W    = 16;
	localparam int CH_W     = 8;

	localparam logic [ROW_W-1:0] CHAR_PTS    = ROW_W'(10);
	localparam logic [ROW_W-1:0] START_PTS   = ROW_W'(10);
	localparam logic [ROW_W-1:0] CONSEC_PTS  = ROW_W'(15);
	localparam logic [ROW_W-1:0] FIRST_BONUS = ROW_W'(5);
	localparam logic [ROW_W-1:0] POS_CAP     = ROW_W'(9);
	localparam logic [CH_W-1:0]  SPACE_CH    = 8'h20;

	localparam logic CMD_TEXT  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [CH_W-1:0] ch;
		logic            last;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] score;
		logic             matched;
	} result_t;

	// operands of one DP cell evaluation
	typedef struct packed {
		logic [CH_W-1:0]   txt;
		logic              ws;
		logic [CH_W-1:0]   want;
		logic [ADDR_W-1:0] j;
		logic              in_text;
		logic [CNT_W-1:0]  i;
		logic [ROW_W-1:0]  prev1;
		logic [ROW_W-1:0]  bb;
	} cell_in_t;

	function automatic logic [CH_W-1:0] fold(input logic [CH_W-1:0] c);
		fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic is_alnum(input logic [CH_W-1:0] c);
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

/* sv/fwms_cell.sv */
module fwms_cell (
	input  fwms_pkg::cell_in_t          ci,
	output logic [fwms_pkg::ROW_W-1:0] v
);
	import fwms_pkg::*;

	logic             hit;
	logic [ROW_W-1:0] cs;
	logic [ROW_W-1:0] jw;
	logic [ROW_W-1:0] pen;
	logic [ROW_W-1:0] first_v;
	logic [ROW_W-1:0] cons;
	logic [ROW_W-1:0] from;

	always_comb begin
		hit = ci.in_text && ({1'b0, ci.j} >= ci.i) && (fold(ci.txt) == ci.want);
		cs = ci.ws ? CHAR_PTS + START_PTS : CHAR_PTS;
		jw = ROW_W'(ci.j);
		pen = (jw < POS_CAP) ? jw : POS_CAP;
		first_v = cs + ((ci.j == '0) ? FIRST_BONUS : '0) - pen;
		// prev1 is zero at j = 0, so no consecutive path there
		cons = (ci.prev1 != '0) ? ci.prev1 + CONSEC_PTS : '0;
		from = (cons > ci.bb) ? cons : ci.bb;
		if (!hit) begin
			v = '0;
		end else if (ci.i == '0) begin
			v = first_v;
		end else if (from != '0) begin
			v = from + cs;
		end else begin
			v = '0;
		end
	end

endmodule

/* sv/fuzzy_word_match_scorer_unit.sv */
// Channel   Handshake            Payload
// item      start / busy         item_t   {cmd, ch, last}
// result    done (1-cycle strobe) result_t {score, matched}
//
// A text word is stored as it is accepted; busy stays low. A query word other than a space
// walks all TEXT_LEN row entries through the single DP cell. A word close scans the stored
// row for its maximum over the text length.
// So a query word keeps busy high until its row walk and any word close are done.
// arst_n clears control state; text and row memories are not cleared.
// done rises in the cycle after the last query word's close; the receiver cannot stall.
module fuzzy_word_match_scorer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fwms_pkg::item_t   item,
	output logic              done,
	output fwms_pkg::result_t result
);
	import fwms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROW   = 3'b010,
		ST_CLOSE = 3'b100
	} state_t;

	state_t state_q;

	logic [CH_W:0]      text_mem [TEXT_LEN];
	logic [ROW_W-1:0]   row_mem  [TEXT_LEN];

	logic [CNT_W-1:0]   cnt_q;
	logic [CH_W-1:0]    want_q;
	logic               qlast_q;
	logic [CNT_W-1:0]   text_count_q;
	logic               text_done_q;
	logic [CH_W-1:0]    prev_ch_q;
	logic [CNT_W-1:0]   word_index_q;
	logic [SUM_W-1:0]   sum_q;
	logic               failed_q;
	logic [ROW_W-1:0]   best_q;
	logic [ROW_W-1:0]   prev1_q;
	logic [ROW_W-1:0]   bb_q;
	logic               done_q;
	result_t            result_q;

	logic               row_vld_s1;
	logic               cls_vld_s1;
	logic [ADDR_W-1:0]  row_j_s1;
	logic [CH_W:0]      text_rd_s1;
	logic [ROW_W-1:0]   row_rd_s1;

	logic               accept;
	logic               text_we;
	logic [CNT_W-1:0]   eff_count;
	logic               ws_new;
	logic               row_issue;
	logic               cls_issue;
	logic               rd_en;
	logic               cls_fin;
	logic [ROW_W-1:0]   best_fin;
	logic [SUM_W+1:0]   sum_wide;
	logic [SUM_W-1:0]   sum_n;
	logic               failed_n;
	cell_in_t           ci;
	logic [ROW_W-1:0]   cell_v;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign eff_count = text_done_q ? '0 : text_count_q;
	assign text_we   = accept && (item.cmd == CMD_TEXT) && (eff_count < CNT_W'(TEXT_LEN));
	assign ws_new    = (eff_count == '0) || !is_alnum(prev_ch_q);

	assign row_issue = (state_q == ST_ROW) && (cnt_q < CNT_W'(TEXT_LEN));
	assign cls_issue = (state_q == ST_CLOSE) && (word_index_q != '0) && (cnt_q < text_count_q);
	assign rd_en     = row_issue || cls_issue;
	assign cls_fin   = (state_q == ST_CLOSE) &&
		((word_index_q == '0) || (cnt_q >= text_count_q));

	always_comb begin
		ci.txt     = text_rd_s1[CH_W-1:0];
		ci.ws      = text_rd_s1[CH_W];
		ci.want    = want_q;
		ci.j       = row_j_s1;
		ci.in_text = ({1'b0, row_j_s1} < text_count_q);
		ci.i       = word_index_q;
		ci.prev1   = prev1_q;
		ci.bb      = bb_q;
	end

	fwms_cell u_cell (
		.ci (ci),
		.v  (cell_v)
	);

	always_comb begin
		best_fin = (cls_vld_s1 && row_rd_s1 > best_q) ? row_rd_s1 : best_q;
		sum_wide = {2'b00, sum_q} + (SUM_W+2)'(best_fin);
		failed_n = failed_q;
		sum_n    = sum_q;
		if (word_index_q != '0) begin
			if (best_fin == '0) begin
				failed_n = 1'b1;
			end else if (sum_wide > (SUM_W+2)'({SUM_W{1'b1}})) begin
				sum_n = '1;
			end else begin
				sum_n = sum_wide[SUM_W-1:0];
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (text_we) begin
			text_mem[eff_count[ADDR_W-1:0]] <= {ws_new, item.ch};
		end
		if (row_issue) begin
			text_rd_s1 <= text_mem[cnt_q[ADDR_W-1:0]];
		end
		if (row_vld_s1) begin
			row_mem[row_j_s1] <= cell_v;
		end
		if (rd_en) begin
			row_rd_s1 <= row_mem[cnt_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		row_j_s1 <= cnt_q[ADDR_W-1:0];
		if (accept) begin
			want_q  <= fold(item.ch);
			qlast_q <= item.last;
		end
		if (text_we) begin
			prev_ch_q <= item.ch;
		end
		if (done_q == 1'b0 && cls_fin && qlast_q) begin
			result_q.score   <= failed_n ? '0 : sum_n;
			result_q.matched <= !failed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			text_count_q <= '0;
			text_done_q  <= 1'b0;
			word_index_q <= '0;
			sum_q        <= '0;
			failed_q     <= 1'b0;
			best_q       <= '0;
			prev1_q      <= '0;
			bb_q         <= '0;
			row_vld_s1   <= 1'b0;
			cls_vld_s1   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			row_vld_s1 <= row_issue;
			cls_vld_s1 <= cls_issue;
			done_q     <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && item.cmd == CMD_TEXT) begin
						text_count_q <= text_we ? eff_count + 1'b1 : eff_count;
						text_done_q  <= item.last;
					end else if (accept) begin
						cnt_q <= '0;
						if (item.ch == SPACE_CH) begin
							best_q  <= '0;
							state_q <= ST_CLOSE;
						end else begin
							prev1_q <= '0;
							bb_q    <= '0;
							state_q <= ST_ROW;
						end
					end
				end
				ST_ROW: begin
					if (row_vld_s1) begin
						prev1_q <= row_rd_s1;
						bb_q    <= (prev1_q > bb_q) ? prev1_q : bb_q;
					end
					if (cnt_q == CNT_W'(TEXT_LEN)) begin
						if (word_index_q < CNT_W'(TEXT_LEN)) begin
							word_index_q <= word_index_q + 1'b1;
						end
						cnt_q  <= '0;
						best_q <= '0;
						state_q <= qlast_q ? ST_CLOSE : ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CLOSE: begin
					if (cls_fin) begin
						word_index_q <= '0;
						state_q      <= ST_IDLE;
						if (qlast_q) begin
							done_q   <= 1'b1;
							sum_q    <= '0;
							failed_q <= 1'b0;
						end else begin
							sum_q    <= sum_n;
							failed_q <= failed_n;
						end
					end else begin
						best_q <= best_fin;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// result strobe only once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a query word always occupies the sequencer
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_QUERY) |=> busy)
		else $error("query word not taken up");

	// row writes come only from the row walk
	a_row_write: assert property (@(posedge clk) disable iff (!arst_n)
		row_vld_s1 |-> (state_q == ST_ROW))
		else $error("row write outside row walk");

	a_word_index: assert property (@(posedge clk) disable iff (!arst_n)
		word_index_q <= CNT_W'(TEXT_LEN))
		else $error("word index past text length");

endmodule

/* verif/fuzzy_word_match_scorer_unit_tb.sv */
module fuzzy_word_match_scorer_unit_tb;
	import fwms_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_WORDS = 255;
	localparam int DRAIN_CYCLES = 200;

	typedef logic [CH_W-1:0] byte_q_t[$];

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	logic    busy;
	item_t   item   = '0;
	logic    done;
	result_t result;

	fuzzy_word_match_scorer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// scorer mirror
	logic [CH_W-1:0]  txt_mem [TEXT_LEN];
	logic             txt_ws  [TEXT_LEN];
	logic [ROW_W-1:0] row_cur [TEXT_LEN];
	logic [CNT_W-1:0] txt_len;
	logic             txt_closed;
	logic [CNT_W-1:0] q_pos;
	logic [SUM_W-1:0] q_sum;
	logic             q_fail;
	result_t          pending_matches[$];
	result_t          head;

	int errors       = 0;
	int words_sent   = 0;
	int results_seen = 0;
	int idle_cycles  = 0;
	bit no_idle      = 1'b0;
	bit req_on       = 1'b0;

	function automatic void add_byte(ref byte_q_t q, input logic [CH_W-1:0] b);
		q.insert(q.size(), b);
	endfunction

	function automatic logic [CH_W-1:0] lower_case(input logic [CH_W-1:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic is_alnum_byte(input logic [CH_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void clear_scorer();
		for (int j = 0; j < TEXT_LEN; j++) begin
			txt_mem[j] = '0;
			txt_ws[j]  = 1'b0;
			row_cur[j] = '0;
		end
		txt_len    = '0;
		txt_closed = 1'b0;
		q_pos      = '0;
		q_sum      = '0;
		q_fail     = 1'b0;
	endfunction

	// one DP row of the current query word over the stored text
	function automatic void walk_row(input logic [CH_W-1:0] q);
		logic [ROW_W-1:0] prev_row [TEXT_LEN];
		logic [ROW_W-1:0] bb, v, cs, cons, from;
		logic [CH_W-1:0]  want;
		prev_row = row_cur;
		bb = '0;
		want = lower_case(q);
		for (int j = 0; j < TEXT_LEN; j++) begin
			v = '0;
			if (j >= 2 && prev_row[j-2] > bb)
				bb = prev_row[j-2];
			if (j < txt_len && j >= q_pos && lower_case(txt_mem[j]) == want) begin
				cs = CHAR_PTS + (txt_ws[j] ? START_PTS : '0);
				if (q_pos == 0) begin
					v = cs + ((j == 0) ? FIRST_BONUS : '0) -
						((j < POS_CAP) ? ROW_W'(j) : POS_CAP);
				end else begin
					cons = (j >= 1 && prev_row[j-1] != 0) ? prev_row[j-1] + CONSEC_PTS : '0;
					from = (cons > bb) ? cons : bb;
					if (from != 0)
						v = from + cs;
				end
			end
			row_cur[j] = v;
		end
		if (q_pos < TEXT_LEN)
			q_pos++;
	endfunction

	function automatic void close_query_word();
		logic [ROW_W-1:0] best;
		int tot;
		if (q_pos == 0)
			return;
		best = '0;
		for (int j = 0; j < txt_len; j++)
			if (row_cur[j] > best)
				best = row_cur[j];
		if (best == 0) begin
			q_fail = 1'b1;
		end else begin
			tot = q_sum + best;
			q_sum = (tot > 65535) ? 16'hFFFF : SUM_W'(tot);
		end
		q_pos = '0;
	endfunction

	function automatic void predict_match(input item_t w);
		result_t r;
		if (w.cmd == CMD_TEXT) begin
			if (txt_closed) begin
				txt_len    = '0;
				txt_closed = 1'b0;
			end
			if (txt_len < TEXT_LEN) begin
				txt_mem[txt_len] = w.ch;
				txt_ws[txt_len]  = (txt_len == 0) ? 1'b1 : !is_alnum_byte(txt_mem[txt_len-1]);
				txt_len++;
			end
			if (w.last)
				txt_closed = 1'b1;
		end else begin
			if (w.ch == SPACE_CH)
				close_query_word();
			else
				walk_row(w.ch);
			if (w.last) begin
				close_query_word();
				r.score   = q_fail ? '0 : q_sum;
				r.matched = !q_fail;
				pending_matches.insert(pending_matches.size(), r);
				q_pos  = '0;
				q_sum  = '0;
				q_fail = 1'b0;
			end
		end
	endfunction

	task automatic lower_start();
		if (req_on) begin
			start  <= 1'b0;
			req_on = 1'b0;
		end
	endtask

	task automatic send_word(input logic c, input logic [CH_W-1:0] b, input logic mark_end);
		int gap;
		item_t w;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		w.cmd  = c;
		w.ch   = b;
		w.last = mark_end;
		if (gap > 0) begin
			lower_start();
			repeat (gap) @(posedge clk);
		end
		item   <= w;
		start  <= 1'b1;
		req_on = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_match(w);
		words_sent++;
	endtask

	task automatic send_seq(input logic c, input byte_q_t s, input logic mark_end);
		foreach (s[k])
			send_word(c, s[k], mark_end && (k == s.size() - 1));
	endtask

	task automatic wait_drained();
		lower_start();
		@(posedge clk);
		while (pending_matches.size() != 0) @(posedge clk);
	endtask

	function automatic byte_q_t from_str(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			add_byte(q, s[i]);
		return q;
	endfunction

	function automatic logic [CH_W-1:0] pick_text_char();
		string punct;
		punct = "-_ .";
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return CH_W'("a" + $urandom_range(0, 4));
			5, 6:          return CH_W'("A" + $urandom_range(0, 4));
			7:             return CH_W'("0" + $urandom_range(0, 9));
			8:             return punct[$urandom_range(0, 3)];
			default:       return CH_W'($urandom_range(0, 255));
		endcase
	endfunction

	// words mostly drawn as ordered picks from the text, case flipped at random
	function automatic byte_q_t build_query(input byte_q_t t);
		byte_q_t q;
		logic [CH_W-1:0] c;
		int nw, len, pos;
		nw = $urandom_range(1, 3);
		if ($urandom_range(0, 4) == 0)
			add_byte(q, SPACE_CH);
		for (int w = 0; w < nw; w++) begin
			if (w > 0)
				repeat ($urandom_range(1, 2)) add_byte(q, SPACE_CH);
			len = $urandom_range(1, 4);
			pos = $urandom_range(0, t.size() - 1);
			for (int k = 0; k < len && pos < t.size(); k++) begin
				c = ($urandom_range(0, 4) == 0) ? CH_W'("a" + $urandom_range(0, 25)) : t[pos];
				if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
						$urandom_range(0, 1))
					c = c ^ 8'h20;
				add_byte(q, c);
				pos += $urandom_range(1, 3);
			end
		end
		if ($urandom_range(0, 4) == 0)
			add_byte(q, SPACE_CH);
		return q;
	endfunction

	task automatic test_directed();
		byte_q_t t;
		t = from_str("Ab-9z");
		t.push_front(8'h00);
		add_byte(t, 8'hFF);
		send_seq(CMD_TEXT, t, 1'b1);
		send_seq(CMD_QUERY, from_str(" "), 1'b1);      // only spaces: 0, matched
		send_seq(CMD_QUERY, from_str("a Z"), 1'b1);
		send_seq(CMD_QUERY, from_str("bq"), 1'b1);     // q absent: fail
		send_seq(CMD_QUERY, from_str("  9 "), 1'b1);   // leading, double, trailing spaces
		send_word(CMD_QUERY, 8'hFF, 1'b1);
		// new text starts, query lands mid-load
		send_word(CMD_TEXT, "x", 1'b0);
		send_word(CMD_QUERY, "X", 1'b1);
		send_word(CMD_TEXT, "y", 1'b1);
	endtask

	task automatic test_text_limits();
		byte_q_t t;
		repeat (TEXT_LEN) add_byte(t, "m");
		repeat (6) add_byte(t, "q");                   // past the store, dropped
		send_seq(CMD_TEXT, t, 1'b1);
		send_seq(CMD_QUERY, from_str("q"), 1'b1);
		send_seq(CMD_QUERY, from_str("mM"), 1'b1);
		send_seq(CMD_TEXT, from_str("abc"), 1'b1);
		send_seq(CMD_QUERY, from_str("abcd"), 1'b1);   // word longer than text
		t.delete();
		repeat (TEXT_LEN) add_byte(t, "a");
		send_seq(CMD_TEXT, t, 1'b1);
		send_seq(CMD_QUERY, t, 1'b1);
		add_byte(t, "a");
		add_byte(t, "a");
		send_seq(CMD_QUERY, t, 1'b1);                  // word index saturates
	endtask

	task automatic test_random();
		byte_q_t t;
		int base, len, sel;
		base = words_sent;
		while (words_sent < base + RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				no_idle = !no_idle;
			sel = $urandom_range(0, 9);
			t.delete();
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 16);
			repeat (len) add_byte(t, pick_text_char());
			if (sel < 7) begin
				send_seq(CMD_TEXT, t, 1'b1);
				repeat ($urandom_range(1, 3)) send_seq(CMD_QUERY, build_query(t), 1'b1);
			end else if (sel < 9) begin
				repeat ($urandom_range(1, 6))
					send_word(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)),
						$urandom_range(0, 3) == 0);
			end else begin
				wait_drained();
				// text left open, queried, then extended
				send_seq(CMD_TEXT, t, 1'b0);
				send_seq(CMD_QUERY, build_query(t), 1'b1);
				send_word(CMD_TEXT, pick_text_char(), 1'b1);
			end
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (pending_matches.size() == 0) begin
				errors++;
				$display("%0t: unexpected result score=%0d matched=%0b",
					$time, result.score, result.matched);
			end else begin
				head = pending_matches.pop_front();
				results_seen++;
				if (result.score !== head.score) begin
					errors++;
					$display("%0t: score expected %0d actual %0d",
						$time, head.score, result.score);
				end
				if (result.matched !== head.matched) begin
					errors++;
					$display("%0t: matched expected %0b actual %0b",
						$time, head.matched, result.matched);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clear_scorer();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_text_limits();
		wait_drained();
		test_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered: directed cases, text overflow, long words, random traffic");
		$display("words sent %0d, results compared %0d, mismatches %0d",
			words_sent, results_seen, errors);
		if (errors == 0 && pending_matches.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
sv/fwms_pkg.sv
sv/fwms_cell.sv
sv/fuzzy_word_match_scorer_unit.sv
verif/fuzzy_word_match_scorer_unit_tb.sv
